### hw/rtl/tvts_pkg.sv
`default_nettype none

package tvts_pkg;

    localparam int FREQ_W = 22;
    localparam int CMP_W = 16;
    localparam int GAP_W = 16;
    localparam int DUR_PORT_W = 10;
    localparam int LEN_W = 9;
    localparam int DIV_W = 23;

    localparam logic [DIV_W-1:0] DIVIDEND = 23'd6250000;
    localparam logic [FREQ_W-1:0] FREQ_MIN = 22'd96;
    localparam logic [FREQ_W-1:0] FREQ_MAX = 22'd3125000;

    localparam logic [1:0] CFG_RIGHT_LENGTH = 2'd0;
    localparam logic [1:0] CFG_LEFT_LENGTH = 2'd1;
    localparam logic [1:0] CFG_ONE_SHOT = 2'd2;

    typedef enum logic [1:0] {
        ACT_TICK     = 2'd0,
        ACT_WR_RIGHT = 2'd1,
        ACT_WR_LEFT  = 2'd2,
        ACT_START    = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP_R,
        S_STEP_L,
        S_APPLY_R,
        S_DIV_R,
        S_APPLY_L,
        S_DIV_L,
        S_OUT
    } t_state;

    typedef struct packed {
        t_action                 action;
        logic [7:0]              note_index;
        logic [FREQ_W-1:0]       note_frequency;
        logic [DUR_PORT_W-1:0]   note_duration;
    } t_in;

    typedef struct packed {
        logic              right_enable;
        logic [CMP_W-1:0]  right_compare;
        logic              right_restart;
        logic              left_enable;
        logic [CMP_W-1:0]  left_compare;
        logic              left_restart;
        logic              song_over;
    } t_out;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

`default_nettype wire

### hw/rtl/tvts_note_ram.sv
`default_nettype none

module tvts_note_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/tvts_divider.sv
`default_nettype none

module tvts_divider (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [tvts_pkg::FREQ_W-1:0]   i_divisor,
    output tvts_pkg::t_div_status              o_status,
    output logic      [tvts_pkg::CMP_W-1:0]    o_quotient
);

    import tvts_pkg::*;

    localparam int CW = $clog2(DIV_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [FREQ_W-1:0] r_div, n_div;
    logic [FREQ_W-1:0] r_rem, n_rem;
    logic [DIV_W-1:0]  r_quo, n_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_div <= n_div;
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    always_comb begin
        logic [DIV_W-1:0] trial;
        logic [DIV_W-1:0] diff;
        logic             ge;
        trial  = {r_rem, r_quo[DIV_W-1]};
        diff   = trial - {1'b0, r_div};
        ge     = trial >= {1'b0, r_div};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_div  = r_div;
        n_rem  = r_rem;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_div  = i_divisor;
            n_rem  = '0;
            n_quo  = DIVIDEND;
        end else if (r_busy) begin
            n_rem = ge ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
            n_quo = {r_quo[DIV_W-2:0], ge};
            n_cnt = r_cnt + CW'(1);
            if (r_cnt == CW'(DIV_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_quo[CMP_W-1:0];

endmodule

`default_nettype wire

### hw/rtl/two_voice_tone_sequencer.sv
`default_nettype none
// A tick request passes from acceptance to result through two table-step states, two apply
// states, up to two waits on the shared 23-step divider (only on a frequency change) and one
// output state; the next request is taken only once the sequencer is back in its idle state.
// Note writes and start requests are taken in idle and give no result. A waiting result holds the
// next tick in its output state. Reset (synchronous, active low) silences both voices until a
// start request; table contents are undefined until written and need no clearing pass.

module two_voice_tone_sequencer #(
    parameter int TABLE_DEPTH = 256,
    parameter int DURATION_BITS = 10
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire tvts_pkg::t_in                i_in,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output tvts_pkg::t_out                    o_out,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [1:0]                   i_cfg_index,
    input  wire logic [tvts_pkg::LEN_W-1:0]   i_cfg_data
);

    import tvts_pkg::*;

    localparam int PW = $clog2(TABLE_DEPTH);
    localparam int LW = (PW + 1 > LEN_W) ? PW + 1 : LEN_W;
    localparam int TW = DURATION_BITS + 2;
    localparam int NW = FREQ_W + DURATION_BITS;

    t_state                r_state, n_state;
    logic [LEN_W-1:0]      r_rlen, r_llen;
    logic                  r_one_shot;
    logic [PW-1:0]         r_rpos, n_rpos, r_lpos, n_lpos;
    logic signed [TW-1:0]  r_rtc, n_rtc, r_ltc, n_ltc;
    logic [GAP_W-1:0]      r_rgap, n_rgap, r_lgap, n_lgap;
    logic [FREQ_W-1:0]     r_rlast, n_rlast, r_llast, n_llast;
    logic [CMP_W-1:0]      r_rcmp, n_rcmp, r_lcmp, n_lcmp;
    logic                  r_silenced, n_silenced;
    logic [FREQ_W-1:0]     r_rf, n_rf, r_lf, n_lf;
    logic                  r_rrst, n_rrst, r_lrst, n_lrst;
    logic                  r_out_valid, n_out_valid;
    t_out                  r_out, n_out;

    logic                  in_fire, rd_en, wr_en_r, wr_en_l, idx_ok;
    logic [PW-1:0]         wr_addr;
    logic [NW-1:0]         wr_data, r_rd_data, l_rd_data;
    logic [LW-1:0]         rlen_eff, llen_eff;
    logic                  div_start;
    logic [FREQ_W-1:0]     div_divisor;
    t_div_status           div_status;
    logic [CMP_W-1:0]      div_quotient;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign in_fire     = i_in_valid && o_in_ready;
    assign idx_ok      = 32'(i_in.note_index) < TABLE_DEPTH;
    assign wr_addr     = PW'(i_in.note_index);
    assign wr_data     = {i_in.note_frequency, DURATION_BITS'(i_in.note_duration)};
    assign rd_en       = in_fire && (i_in.action == ACT_TICK);
    assign wr_en_r     = in_fire && (i_in.action == ACT_WR_RIGHT) && idx_ok;
    assign wr_en_l     = in_fire && (i_in.action == ACT_WR_LEFT) && idx_ok;
    assign div_divisor = (r_state == S_APPLY_L) ? r_lf : r_rf;

    always_comb begin
        if (r_rlen == '0) begin
            rlen_eff = LW'(1);
        end else if (LW'(r_rlen) > LW'(TABLE_DEPTH)) begin
            rlen_eff = LW'(TABLE_DEPTH);
        end else begin
            rlen_eff = LW'(r_rlen);
        end
        if (r_llen == '0) begin
            llen_eff = LW'(1);
        end else if (LW'(r_llen) > LW'(TABLE_DEPTH)) begin
            llen_eff = LW'(TABLE_DEPTH);
        end else begin
            llen_eff = LW'(r_llen);
        end
    end

    tvts_note_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(NW)) u_right_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en_r),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rpos),
        .o_rd_data (r_rd_data)
    );

    tvts_note_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(NW)) u_left_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en_l),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_lpos),
        .o_rd_data (l_rd_data)
    );

    tvts_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_divisor  (div_divisor),
        .o_status   (div_status),
        .o_quotient (div_quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rlen      <= LEN_W'(1);
            r_llen      <= LEN_W'(1);
            r_one_shot  <= 1'b0;
            r_rpos      <= '0;
            r_lpos      <= '0;
            r_rtc       <= '0;
            r_ltc       <= '0;
            r_rgap      <= '0;
            r_lgap      <= '0;
            r_rlast     <= '0;
            r_llast     <= '0;
            r_rcmp      <= '0;
            r_lcmp      <= '0;
            r_silenced  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rpos      <= n_rpos;
            r_lpos      <= n_lpos;
            r_rtc       <= n_rtc;
            r_ltc       <= n_ltc;
            r_rgap      <= n_rgap;
            r_lgap      <= n_lgap;
            r_rlast     <= n_rlast;
            r_llast     <= n_llast;
            r_rcmp      <= n_rcmp;
            r_lcmp      <= n_lcmp;
            r_silenced  <= n_silenced;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_RIGHT_LENGTH: r_rlen <= i_cfg_data;
                    CFG_LEFT_LENGTH:  r_llen <= i_cfg_data;
                    CFG_ONE_SHOT:     r_one_shot <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        r_rf   <= n_rf;
        r_lf   <= n_lf;
        r_rrst <= n_rrst;
        r_lrst <= n_lrst;
        r_out  <= n_out;
    end

    always_comb begin
        logic [FREQ_W-1:0]        freq;
        logic [DURATION_BITS-1:0] dur;
        logic signed [TW-1:0]     tcn;
        logic [GAP_W-1:0]         gdiff;
        logic                     ge;
        freq        = '0;
        dur         = '0;
        tcn         = '0;
        gdiff       = '0;
        ge          = 1'b0;
        n_state     = r_state;
        n_rpos      = r_rpos;
        n_lpos      = r_lpos;
        n_rtc       = r_rtc;
        n_ltc       = r_ltc;
        n_rgap      = r_rgap;
        n_lgap      = r_lgap;
        n_rlast     = r_rlast;
        n_llast     = r_llast;
        n_rcmp      = r_rcmp;
        n_lcmp      = r_lcmp;
        n_silenced  = r_silenced;
        n_rf        = r_rf;
        n_lf        = r_lf;
        n_rrst      = r_rrst;
        n_lrst      = r_lrst;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        div_start   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    unique case (i_in.action)
                        ACT_TICK: n_state = S_STEP_R;
                        ACT_START: begin
                            n_rpos     = '0;
                            n_lpos     = '0;
                            n_rtc      = '0;
                            n_ltc      = '0;
                            n_rgap     = '0;
                            n_lgap     = '0;
                            n_silenced = 1'b0;
                        end
                        ACT_WR_RIGHT, ACT_WR_LEFT: ;
                    endcase
                end
            end
            S_STEP_R: begin
                n_rf    = '0;
                n_state = S_STEP_L;
                if (!r_silenced) begin
                    if (r_rtc[TW-1]) begin
                        n_rtc = r_rtc + TW'(1);
                    end else begin
                        freq  = r_rd_data[NW-1 -: FREQ_W];
                        dur   = r_rd_data[DURATION_BITS-1:0];
                        n_rf  = freq;
                        tcn   = r_rtc + TW'(1);
                        n_rtc = tcn;
                        if (tcn[DURATION_BITS:0] >=
                                ({1'b0, dur} + (DURATION_BITS+1)'(1))) begin
                            gdiff  = r_rgap - r_lgap;
                            ge     = !gdiff[GAP_W-1];
                            n_rtc  = ge ? {TW{1'b1}} : {{(TW-1){1'b1}}, 1'b0};
                            n_rgap = r_rgap + (ge ? GAP_W'(1) : GAP_W'(2));
                            n_rpos = (LW'(r_rpos) + LW'(1) >= rlen_eff) ? '0
                                                                       : r_rpos + PW'(1);
                        end
                    end
                end
            end
            S_STEP_L: begin
                n_lf    = '0;
                n_state = S_APPLY_R;
                if (!r_silenced) begin
                    if (r_ltc[TW-1]) begin
                        n_ltc = r_ltc + TW'(1);
                    end else begin
                        freq  = l_rd_data[NW-1 -: FREQ_W];
                        dur   = l_rd_data[DURATION_BITS-1:0];
                        n_lf  = freq;
                        tcn   = r_ltc + TW'(1);
                        n_ltc = tcn;
                        if (tcn[DURATION_BITS:0] >=
                                ({1'b0, dur} + (DURATION_BITS+1)'(1))) begin
                            gdiff  = r_lgap - r_rgap;
                            ge     = !gdiff[GAP_W-1];
                            n_ltc  = ge ? {TW{1'b1}} : {{(TW-1){1'b1}}, 1'b0};
                            n_lgap = r_lgap + (ge ? GAP_W'(1) : GAP_W'(2));
                            if (r_one_shot && (LW'(r_lpos) + LW'(1) == llen_eff)) begin
                                n_rpos     = '0;
                                n_lpos     = '0;
                                n_rtc      = '0;
                                n_ltc      = '0;
                                n_rgap     = '0;
                                n_lgap     = '0;
                                n_silenced = 1'b1;
                            end else begin
                                n_lpos = (LW'(r_lpos) + LW'(1) >= llen_eff) ? '0
                                                                           : r_lpos + PW'(1);
                            end
                        end
                    end
                end
            end
            S_APPLY_R: begin
                n_state = S_APPLY_L;
                n_rrst  = (r_rf != r_rlast);
                if (r_rf != r_rlast) begin
                    n_rlast = r_rf;
                    if (r_rf < FREQ_MIN) begin
                        n_rcmp = '1;
                    end else if (r_rf > FREQ_MAX) begin
                        n_rcmp = '0;
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_DIV_R;
                    end
                end
            end
            S_DIV_R: begin
                if (div_status.done) begin
                    n_rcmp  = div_quotient - CMP_W'(1);
                    n_state = S_APPLY_L;
                end
            end
            S_APPLY_L: begin
                n_state = S_OUT;
                n_lrst  = (r_lf != r_llast);
                if (r_lf != r_llast) begin
                    n_llast = r_lf;
                    if (r_lf < FREQ_MIN) begin
                        n_lcmp = '1;
                    end else if (r_lf > FREQ_MAX) begin
                        n_lcmp = '0;
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_DIV_L;
                    end
                end
            end
            S_DIV_L: begin
                if (div_status.done) begin
                    n_lcmp  = div_quotient - CMP_W'(1);
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!n_out_valid) begin
                    n_out_valid         = 1'b1;
                    n_out.right_enable  = (r_rlast != '0);
                    n_out.right_compare = r_rcmp;
                    n_out.right_restart = r_rrst;
                    n_out.left_enable   = (r_llast != '0);
                    n_out.left_compare  = r_lcmp;
                    n_out.left_restart  = r_lrst;
                    n_out.song_over     = r_silenced;
                    n_state             = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_silenced_rewound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_silenced |-> (r_rpos == '0 && r_lpos == '0 && r_rtc == '0 && r_ltc == '0 &&
                        r_rgap == '0 && r_lgap == '0))
        else $error("silenced with voice state not rewound");

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_status.busy)
        else $error("divider started while busy");

    a_div_wait_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_R || r_state == S_DIV_L) |-> (div_status.busy || div_status.done))
        else $error("waiting on an idle divider");

    a_out_from_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result raised outside output state");

endmodule

`default_nettype wire
